// ===== src/mva_pkg.sv =====
// Package for the MIDI voice allocator: sizes, codes, controller states and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package mva_pkg;
  localparam int FM_VOICES = 6;
  localparam int PSG_TONE_VOICES = 3;
  localparam int NOISE_VOICE = FM_VOICES + PSG_TONE_VOICES;
  localparam int NUM_VOICES = NOISE_VOICE + 1;
  localparam int LAST_TONE = FM_VOICES + PSG_TONE_VOICES - 1;
  localparam int NUM_CHANNELS = 16;
  localparam int MAX_PERCUSSION_VOICES = 2;
  localparam logic [3:0] PERCUSSION_CHANNEL = 4'd9;
  localparam logic [4:0] UNASSIGNED = 5'd16;
  localparam logic [6:0] PROG_SQ_A = 7'd80;
  localparam logic [6:0] PROG_SQ_B = 7'd89;
  localparam logic [6:0] PROG_SQ_C = 7'd99;
  localparam int VW = 4;

  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [1:0] CMD_PROGRAM  = 2'd2;
  localparam logic [1:0] CMD_DEVICE   = 2'd3;

  localparam logic [1:0] RES_ON   = 2'd0;
  localparam logic [1:0] RES_OFF  = 2'd1;
  localparam logic [1:0] RES_DROP = 2'd2;
  localparam logic [1:0] RES_ACK  = 2'd3;

  localparam logic [1:0] MODE_AUTO  = 2'd0;
  localparam logic [1:0] MODE_FM    = 2'd1;
  localparam logic [1:0] MODE_TONE  = 2'd2;
  localparam logic [1:0] MODE_NOISE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_PERC, ST_OWN, ST_SQUARE, ST_FIRST, ST_FREE,
    ST_STEAL, ST_ANY, ST_OFF, ST_EMIT, ST_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic          load;     // capture input word
    logic          scan_clr; // voice counter to scan start
    logic          scan_inc;
    logic [1:0]    scan_sel; // 0: lo, 1: FM_VOICES, 2: 0, 3: steal lo
    logic          perc_clr;
    logic          perc_acc;
    logic          pick;     // latch found voice
    logic          assign_v; // start the picked voice
    logic          release_v;// release the voice under the counter
    logic          wr_prog;
    logic          wr_mode;
    logic          set_first;
    logic          emit;     // load output register
    logic [1:0]    emit_res;
    logic          emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;   // velocity-zero note on already folded to off
    logic       is_perc;
    logic       perc_full;
    logic       square;
    logic       stick;
    logic       own_hit;   // owned and usable at counter
    logic       free_hit;  // usable at counter
    logic       steal_hit;
    logic       owner_hit; // owner == channel at counter
    logic       off_hit;
    logic       off_more;  // another off match above the counter
    logic       at_hi;     // counter == hi (inclusive end)
    logic       at_hi_x;   // counter >= hi (exclusive end)
    logic       sq_end;
    logic       sh_end;    // counter == steal hi
    logic       vend;      // counter == last voice
    logic       first_ok;
    logic       any_off;   // an off result was sent
    logic       out_busy;
  } sts_t;
endpackage
`default_nettype wire

// ===== src/mva_datapath.sv =====
// Datapath of the voice allocator: voice and channel tables, scan counter,
// output register. Depends on mva_pkg.
`default_nettype none
module mva_datapath import mva_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [1:0]  in_command,
  input  wire logic [3:0]  in_channel,
  input  wire logic [6:0]  in_pitch,
  input  wire logic [6:0]  in_data,
  input  wire logic        stick_cfg,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_res,
  output logic [VW-1:0]    out_voice,
  output logic [6:0]       out_pitch,
  output logic [6:0]       out_vel,
  output logic             out_last
);
  logic [4:0] owner_r [NUM_VOICES];
  logic [NUM_VOICES-1:0] snd_r;
  logic [6:0] vpitch_r [NUM_VOICES];
  logic [6:0] prog_r [NUM_CHANNELS];
  logic [1:0] mode_r [NUM_CHANNELS];
  logic [1:0] cmd_r;
  logic [3:0] ch_r;
  logic [6:0] p_r, d_r;
  logic [VW-1:0] v_r, pick_r, slo_r, shi_r;
  logic [3:0] perc_r;
  logic first_ok_r, sent_r, ov_r;
  logic [VW-1:0] lo, hi;
  logic [1:0] mode;
  logic usable, owned;
  logic off_more;
  logic [VW:0] ov_v;

  assign mode = mode_r[ch_r];
  always_comb begin
    unique case (mode)
      MODE_AUTO: begin lo = '0; hi = VW'(LAST_TONE); end
      MODE_FM: begin lo = '0; hi = VW'(FM_VOICES - 1); end
      MODE_TONE: begin lo = VW'(FM_VOICES); hi = VW'(LAST_TONE); end
      default: begin lo = VW'(NOISE_VOICE); hi = VW'(NOISE_VOICE); end
    endcase
  end
  assign owned = owner_r[v_r] == {1'b0, ch_r};
  assign usable = !snd_r[v_r] &&
                  !(v_r >= VW'(FM_VOICES) && ch_r == PERCUSSION_CHANNEL);

  always_comb begin
    off_more = 1'b0;
    for (int i = 0; i < NUM_VOICES; i++)
      if (VW'(i) > v_r && snd_r[i] && owner_r[i] == {1'b0, ch_r} && vpitch_r[i] == p_r)
        off_more = 1'b1;
  end

  always_comb begin
    sts.command = (cmd_r == CMD_NOTE_ON && d_r == '0) ? CMD_NOTE_OFF : cmd_r;
    sts.is_perc = ch_r == PERCUSSION_CHANNEL;
    sts.perc_full = perc_r >= 4'(MAX_PERCUSSION_VOICES);
    sts.square = prog_r[ch_r] == PROG_SQ_A || prog_r[ch_r] == PROG_SQ_B ||
                 prog_r[ch_r] == PROG_SQ_C;
    sts.stick = stick_cfg;
    sts.own_hit = owned && usable;
    sts.free_hit = usable;
    sts.steal_hit = owned &&
                    !(v_r >= VW'(FM_VOICES) && ch_r == PERCUSSION_CHANNEL);
    sts.owner_hit = owned;
    sts.off_hit = snd_r[v_r] && owned && vpitch_r[v_r] == p_r;
    sts.off_more = off_more;
    sts.at_hi = v_r == hi;
    sts.at_hi_x = v_r >= hi;
    sts.sq_end = v_r >= VW'(LAST_TONE);
    sts.sh_end = v_r == shi_r;
    sts.vend = v_r == VW'(NUM_VOICES - 1);
    sts.first_ok = first_ok_r;
    sts.any_off = sent_r;
    sts.out_busy = ov_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command; ch_r <= in_channel; p_r <= in_pitch; d_r <= in_data;
    end
    if (cmd.scan_clr) begin
      unique case (cmd.scan_sel)
        2'd0: v_r <= lo;
        2'd1: v_r <= VW'(FM_VOICES);
        2'd2: v_r <= '0;
        default: v_r <= cmd.set_first ?
                        ((v_r < VW'(FM_VOICES)) ? '0 : VW'(FM_VOICES)) : slo_r;
      endcase
    end else if (cmd.scan_inc) begin
      v_r <= v_r + 1'b1;
    end
    if (cmd.pick) pick_r <= v_r;
    if (cmd.set_first) begin
      if (v_r < VW'(FM_VOICES)) begin slo_r <= '0; shi_r <= VW'(FM_VOICES - 1); end
      else begin slo_r <= VW'(FM_VOICES); shi_r <= VW'(LAST_TONE); end
    end else if (cmd.load) begin
      slo_r <= '0; shi_r <= '0;
    end
    if (cmd.emit) begin
      out_res <= cmd.emit_res;
      out_voice <= (cmd.emit_res == RES_ON) ? pick_r :
                   (cmd.emit_res == RES_OFF) ? v_r : '0;
      out_pitch <= (cmd.emit_res == RES_ACK) ? '0 : p_r;
      out_vel <= (cmd.emit_res == RES_ON) ? d_r : '0;
      out_last <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        owner_r[i] <= UNASSIGNED; vpitch_r[i] <= '0;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prog_r[i] <= '0; mode_r[i] <= MODE_AUTO;
      end
      snd_r <= '0; ov_r <= 1'b0; perc_r <= '0; first_ok_r <= 1'b0; sent_r <= 1'b0;
    end else begin
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (cmd.perc_clr) perc_r <= '0;
      else if (cmd.perc_acc && snd_r[v_r] && owner_r[v_r] == {1'b0, PERCUSSION_CHANNEL})
        perc_r <= perc_r + 1'b1;
      if (cmd.load) begin first_ok_r <= 1'b0; sent_r <= 1'b0; end
      else if (cmd.set_first) first_ok_r <= 1'b1;
      if (cmd.release_v) sent_r <= 1'b1;
      if (cmd.assign_v) begin
        owner_r[pick_r] <= {1'b0, ch_r}; vpitch_r[pick_r] <= p_r;
        snd_r[pick_r] <= 1'b1;
      end
      if (cmd.release_v) begin
        snd_r[v_r] <= 1'b0; vpitch_r[v_r] <= '0;
      end
      if (cmd.wr_prog) prog_r[ch_r] <= d_r;
      if (cmd.wr_mode && d_r <= 7'd3) mode_r[ch_r] <= d_r[1:0];
    end
  end
  assign ov_v = {1'b0, pick_r};
  assign out_valid = ov_r && (ov_v[VW] == 1'b0);
endmodule
`default_nettype wire

// ===== src/mva_ctrl.sv =====
// Voice allocator controller: sequences result output and voice searches,
// one voice per cycle unless a note-off waits on output. Depends on mva_pkg.
`default_nettype none
module mva_ctrl import mva_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;
  logic   done_r, done_nxt; // a search picked a voice for this event

  always_ff @(posedge clk) begin
    if (!rst_n) begin state_r <= ST_IDLE; done_r <= 1'b0; end
    else begin state_r <= state_nxt; done_r <= done_nxt; end
  end

  always_comb begin
    logic can_emit;
    can_emit = !sts.out_busy || out_ready;
    cmd = '0;
    state_nxt = state_r;
    done_nxt = done_r;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin cmd.load = 1'b1; state_nxt = ST_DISPATCH; end
      end
      ST_DISPATCH: begin
        cmd.scan_clr = 1'b1;
        unique case (sts.command)
          CMD_NOTE_ON: begin
            cmd.perc_clr = 1'b1;
            if (sts.is_perc) begin cmd.scan_sel = 2'd2; state_nxt = ST_PERC; end
            else begin cmd.scan_sel = 2'd0; state_nxt = ST_OWN; end
          end
          CMD_NOTE_OFF: begin cmd.scan_sel = 2'd2; state_nxt = ST_OFF; end
          CMD_PROGRAM: begin cmd.wr_prog = 1'b1; state_nxt = ST_EMIT; end
          default: begin cmd.wr_mode = 1'b1; state_nxt = ST_EMIT; end
        endcase
      end
      ST_PERC: begin
        cmd.perc_acc = 1'b1; cmd.scan_inc = 1'b1;
        if (sts.vend) begin
          cmd.scan_clr = 1'b1; cmd.scan_sel = 2'd0; state_nxt = ST_OWN;
        end
      end
      ST_OWN: begin
        if (sts.perc_full) state_nxt = ST_EMIT;
        else if (sts.own_hit) begin cmd.pick = 1'b1; state_nxt = ST_EMIT; end
        else if (sts.at_hi) begin
          cmd.scan_clr = 1'b1;
          if (sts.square) begin cmd.scan_sel = 2'd1; state_nxt = ST_SQUARE; end
          else if (sts.stick) begin cmd.scan_sel = 2'd2; state_nxt = ST_FIRST; end
          else begin cmd.scan_sel = 2'd0; state_nxt = ST_FREE; end
        end else cmd.scan_inc = 1'b1;
      end
      ST_SQUARE: begin
        if (!sts.sq_end && sts.free_hit) begin cmd.pick = 1'b1; state_nxt = ST_EMIT; end
        else if (sts.sq_end) begin
          cmd.scan_clr = 1'b1;
          if (sts.stick) begin cmd.scan_sel = 2'd2; state_nxt = ST_FIRST; end
          else begin cmd.scan_sel = 2'd0; state_nxt = ST_FREE; end
        end else cmd.scan_inc = 1'b1;
      end
      ST_FIRST: begin
        if (sts.owner_hit) begin
          cmd.set_first = 1'b1; cmd.scan_clr = 1'b1; cmd.scan_sel = 2'd3;
          state_nxt = ST_FREE;
        end else if (sts.vend) begin
          cmd.scan_clr = 1'b1; cmd.scan_sel = 2'd0; state_nxt = ST_ANY;
        end else cmd.scan_inc = 1'b1;
      end
      ST_FREE: begin
        // range: mode range, or the device range of the first owned voice
        if (sts.free_hit) begin cmd.pick = 1'b1; state_nxt = ST_EMIT; end
        else if (sts.stick ? sts.sh_end : sts.at_hi) begin
          cmd.scan_clr = 1'b1;
          cmd.scan_sel = sts.stick ? 2'd3 : 2'd0;
          state_nxt = ST_STEAL;
        end else cmd.scan_inc = 1'b1;
      end
      ST_STEAL: begin
        if (sts.steal_hit) begin cmd.pick = 1'b1; state_nxt = ST_EMIT; end
        else if (sts.stick ? sts.sh_end : sts.at_hi) begin
          cmd.scan_clr = 1'b1; cmd.scan_sel = 2'd0; state_nxt = ST_ANY;
        end else cmd.scan_inc = 1'b1;
      end
      ST_ANY: begin
        if (sts.at_hi_x) state_nxt = ST_EMIT;
        else if (sts.free_hit) begin cmd.pick = 1'b1; state_nxt = ST_EMIT; end
        else cmd.scan_inc = 1'b1;
      end
      ST_OFF: begin
        if (sts.off_hit) begin
          if (can_emit) begin
            cmd.release_v = 1'b1; cmd.emit = 1'b1; cmd.emit_res = RES_OFF;
            cmd.emit_last = sts.vend || !sts.off_more;
            if (cmd.emit_last) state_nxt = ST_WAIT; else cmd.scan_inc = 1'b1;
          end
        end else if (sts.vend) state_nxt = sts.any_off ? ST_WAIT : ST_EMIT;
        else cmd.scan_inc = 1'b1;
      end
      ST_EMIT: begin
        // pick latched on the cycle a search hit; done_r marks that
        if (can_emit) begin
          cmd.emit = 1'b1; cmd.emit_last = 1'b1;
          if (sts.command == CMD_NOTE_ON) begin
            cmd.emit_res = done_r ? RES_ON : RES_DROP;
            cmd.assign_v = done_r;
          end else cmd.emit_res = RES_ACK;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        done_nxt = 1'b0;
        if (can_emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.pick) done_nxt = 1'b1;
    if (state_r == ST_IDLE) done_nxt = 1'b0;
  end
endmodule
`default_nettype wire

// ===== src/midi_voice_allocator.sv =====
// Searches visit one voice a cycle; the note-off search holds on a match while
// the output is busy. One event at a time: the next event is accepted in the idle
// state, once the last result word of the previous event has been taken.
// Reset (rst_n, synchronous): all voices free and unassigned, programs 0, modes auto.
// Top level: APB register stick_to_device_type at address 0. Depends on mva_pkg.
`default_nettype none
module midi_voice_allocator import mva_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command[1:0], midi_channel[5:2], pitch[12:6], data_value[19:13]
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // event_res[1:0], voice_index[5:2], note_pitch[12:6], note_velocity[19:13]
  output logic [23:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  cmd_t cmd;
  sts_t sts;
  logic stick_r;
  logic [1:0] res;
  logic [VW-1:0] voice;
  logic [6:0] pch, vel;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) stick_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      stick_r <= cfg_pwdata[0];
  end
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {31'd0, stick_r} : 32'd0;

  mva_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .out_ready(out_tready), .sts, .cmd
  );
  mva_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_command(in_tdata[1:0]), .in_channel(in_tdata[5:2]),
    .in_pitch(in_tdata[12:6]), .in_data(in_tdata[19:13]),
    .stick_cfg(stick_r), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_res(res), .out_voice(voice), .out_pitch(pch), .out_vel(vel),
    .out_last(out_tlast)
  );
  assign out_tdata = {4'd0, vel, pch, voice, res};
endmodule
`default_nettype wire

// ===== src/mva_checker.sv =====
// Port-level checker for midi_voice_allocator, bound to the top level.
// Depends on mva_pkg.
`default_nettype none
module mva_props import mva_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out word changed while stalled");
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");
  a_voice: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:2] < 4'(NUM_VOICES))
    else $error("voice index out of range");
  a_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == RES_ACK |-> out_tlast && out_tdata[19:2] == '0)
    else $error("bad ack word");
endmodule

bind midi_voice_allocator mva_props u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tlast
);
`default_nettype wire
